// ===== src/pnfe_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the petri net firing engine
// no dependencies

package pnfe_pkg;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register select bit of paddr (one register, at byte address 0)
  localparam logic REG_ENGINE_ON = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_TOKEN = 3'd0,
    CMD_WR_IN_W  = 3'd1,
    CMD_WR_OUT_W = 3'd2,
    CMD_FIRE     = 3'd3,
    CMD_RD_TOKEN = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_SAT    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] place_index;
    logic [INDEX_W-1:0] transition_index;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   enabled_mask;
    logic [VALUE_W-1:0]  token_value;
  } out_item_t;

endpackage

// ===== src/pnfe_wt_mem.sv =====
`timescale 1ns / 1ps
// arc weight memory: one row per place, one 16-bit lane per transition
// uses pnfe_pkg for the weight width

module pnfe_wt_mem #(
  parameter int unsigned ROWS  = 16,
  parameter int unsigned LANES = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] waddr_i,
  input  logic [LANES-1:0]                          lane_we_i,
  input  logic [pnfe_pkg::WEIGHT_W-1:0]             wdata_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] raddr_i,
  output logic [LANES-1:0][pnfe_pkg::WEIGHT_W-1:0]  rdata_o
);

  logic [LANES-1:0][pnfe_pkg::WEIGHT_W-1:0] mem_q [ROWS];
  logic [LANES-1:0][pnfe_pkg::WEIGHT_W-1:0] rdata_q;

  // lane-masked write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (lane_we_i[l]) begin
          mem_q[waddr_i][l] <= wdata_i;
        end
      end
    end
  end

  // registered row read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/petri_net_firing_engine.sv =====
`timescale 1ns / 1ps
// petri net firing engine top level: marking, arc weights, fire sequencer
// uses pnfe_pkg and pnfe_wt_mem
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_stall_o  in_item_i  (pnfe_pkg::in_item_t)
//   out       output     out_valid_o/out_stall_i out_item_o (pnfe_pkg::out_item_t)
//   config    input      apb psel/penable/pready paddr, pwdata, prdata
//
// after reset a clearing pass walks the marking and weight rows, one place a
// cycle, with in_stall_o high meanwhile. every item is accepted in the idle
// state, then scanned over the places through the token memory read port, and
// its result is loaded into the output register in the finish state.
// one item at a time; the next item may be taken while a result waits on a stall.
// a stalled result holds in the output register until it is taken.

module petri_net_firing_engine #(
  parameter int unsigned PLACES      = 16,
  parameter int unsigned TRANSITIONS = 16,
  parameter int unsigned TOKEN_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pnfe_pkg::in_item_t             in_item_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pnfe_pkg::out_item_t            out_item_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pnfe_pkg::PADDR_W-1:0]   paddr,
  input  logic [pnfe_pkg::PDATA_W-1:0]   pwdata,
  output logic [pnfe_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // places and transitions past 16 cannot be addressed by the 4-bit indexes:
  // their counts and weights stay zero, so they never change any result
  localparam int unsigned P_EFF = (PLACES < 16) ? PLACES : 16;
  localparam int unsigned LANES = (TRANSITIONS < 16) ? TRANSITIONS : 16;
  localparam int unsigned IDX_W = (P_EFF > 1) ? $clog2(P_EFF) : 1;
  localparam int unsigned LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CNT_W = $clog2(P_EFF + 1);
  localparam int unsigned TW    = TOKEN_WIDTH;
  // arithmetic width: room for the widest operand plus a carry
  localparam int unsigned SW    = ((TW > pnfe_pkg::WEIGHT_W) ? TW : pnfe_pkg::WEIGHT_W) + 1;
  localparam logic [SW-1:0] TOKEN_MAX = {{(SW-TW){1'b0}}, {TW{1'b1}}};
  localparam logic [pnfe_pkg::MASK_W-1:0] LANE_ALL =
    pnfe_pkg::MASK_W'((32'd1 << LANES) - 32'd1);

  // sequencer state
  pnfe_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // per-item control
  pnfe_pkg::cmd_e                 cmd_q;
  logic [pnfe_pkg::INDEX_W-1:0]   p_q;
  logic [pnfe_pkg::INDEX_W-1:0]   t_q;
  logic                           p_ok_q;
  logic                           fire_q;
  logic                           sat_q, sat_d;
  logic [pnfe_pkg::VALUE_W-1:0]   tokv_q, tokv_d;

  // enabled mask ignoring engine_on, kept current between items
  logic [pnfe_pkg::MASK_W-1:0]    raw_q, raw_d;

  // scan stage b: data for place b_idx_q is back from the memories
  logic                           b_vld_q, b_vld_d;
  logic [IDX_W-1:0]               b_idx_q, b_idx_d;

  // config register
  logic                           eng_q, eng_d;

  // output register
  logic                           out_vld_q, out_vld_d;
  pnfe_pkg::out_item_t            out_item_q, out_item_d;
  logic                           out_load;

  // memory ports
  logic [TW-1:0]                  tok_mem_q [P_EFF];
  logic [TW-1:0]                  tok_rdata_q;
  logic                           tok_we;
  logic [IDX_W-1:0]               tok_waddr;
  logic [TW-1:0]                  tok_wdata;
  logic [IDX_W-1:0]               rd_addr;

  logic                           in_we, out_we;
  logic [IDX_W-1:0]               wt_waddr;
  logic [LANES-1:0]               wt_lane_we;
  logic [pnfe_pkg::WEIGHT_W-1:0]  wt_wdata;
  logic [LANES-1:0][pnfe_pkg::WEIGHT_W-1:0] in_row, out_row;

  // accept-side decode
  logic                           accept;
  logic                           p_ok, t_ok, fire_ok;
  logic [SW-1:0]                  val_ext;
  logic [TW-1:0]                  val_sat;

  // stage b arithmetic
  logic [pnfe_pkg::WEIGHT_W-1:0]  w_in, w_out;
  logic [SW-1:0]                  tok_ext, sum;
  logic [TW-1:0]                  new_tok;
  logic [SW-1:0]                  new_ext;
  logic                           b_sat;
  logic [pnfe_pkg::MASK_W-1:0]    clr;
  logic [SW-1:0]                  new_low;

  assign accept     = in_valid_i && (state_q == pnfe_pkg::ST_IDLE);
  assign in_stall_o = (state_q != pnfe_pkg::ST_IDLE);

  assign p_ok    = {1'b0, in_item_i.place_index} < (pnfe_pkg::INDEX_W + 1)'(P_EFF);
  assign t_ok    = {1'b0, in_item_i.transition_index} < (pnfe_pkg::INDEX_W + 1)'(LANES);
  assign fire_ok = eng_q && t_ok && raw_q[in_item_i.transition_index];

  // token write saturates at the token maximum
  assign val_ext = {{(SW-pnfe_pkg::VALUE_W){1'b0}}, in_item_i.value};
  assign val_sat = (val_ext > TOKEN_MAX) ? TOKEN_MAX[TW-1:0] : val_ext[TW-1:0];

  // ---------------------------------------------------------------------------
  // stage b: one place per cycle through the shared subtract/add/saturate unit
  // ---------------------------------------------------------------------------
  assign w_in    = in_row[t_q[LW-1:0]];
  assign w_out   = out_row[t_q[LW-1:0]];
  assign tok_ext = {{(SW-TW){1'b0}}, tok_rdata_q};
  // enabling guarantees the count covers the input weight
  assign sum     = tok_ext - {{(SW-pnfe_pkg::WEIGHT_W){1'b0}}, w_in}
                 + {{(SW-pnfe_pkg::WEIGHT_W){1'b0}}, w_out};

  always_comb begin
    b_sat   = 1'b0;
    new_tok = tok_rdata_q;
    if (fire_q) begin
      if (sum > TOKEN_MAX) begin
        b_sat   = 1'b1;
        new_tok = TOKEN_MAX[TW-1:0];
      end else begin
        new_tok = sum[TW-1:0];
      end
    end
  end

  assign new_ext = {{(SW-TW){1'b0}}, new_tok};
  assign new_low = new_ext;

  // a transition drops out of the mask once one place falls short of its weight
  always_comb begin
    clr = '0;
    for (int l = 0; l < LANES; l++) begin
      clr[l] = new_ext < {{(SW-pnfe_pkg::WEIGHT_W){1'b0}}, in_row[l]};
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state, memory controls, per-item bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    raw_d      = raw_q;
    sat_d      = sat_q;
    tokv_d     = tokv_q;
    b_vld_d    = 1'b0;
    b_idx_d    = cnt_q[IDX_W-1:0];
    rd_addr    = cnt_q[IDX_W-1:0];
    tok_we     = 1'b0;
    tok_waddr  = cnt_q[IDX_W-1:0];
    tok_wdata  = '0;
    in_we      = 1'b0;
    out_we     = 1'b0;
    wt_waddr   = cnt_q[IDX_W-1:0];
    wt_lane_we = '1;
    wt_wdata   = '0;
    out_load   = 1'b0;

    unique case (state_q)
      pnfe_pkg::ST_CLEAR: begin
        // zero one place row of every store per cycle
        tok_we = 1'b1;
        in_we  = 1'b1;
        out_we = 1'b1;
        if (cnt_q == CNT_W'(P_EFF - 1)) begin
          cnt_d   = '0;
          state_d = pnfe_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      pnfe_pkg::ST_IDLE: begin
        if (accept) begin
          // the mask is rebuilt by the scan that follows
          raw_d     = LANE_ALL;
          sat_d     = 1'b0;
          tokv_d    = '0;
          cnt_d     = '0;
          state_d   = pnfe_pkg::ST_SCAN;
          tok_waddr = in_item_i.place_index[IDX_W-1:0];
          tok_wdata = val_sat;
          wt_waddr  = in_item_i.place_index[IDX_W-1:0];
          wt_wdata  = in_item_i.value;
          for (int l = 0; l < LANES; l++) begin
            wt_lane_we[l] = (in_item_i.transition_index == pnfe_pkg::INDEX_W'(l));
          end
          case (pnfe_pkg::cmd_e'(in_item_i.cmd))
            pnfe_pkg::CMD_WR_TOKEN: tok_we = p_ok;
            pnfe_pkg::CMD_WR_IN_W:  in_we  = p_ok && t_ok;
            pnfe_pkg::CMD_WR_OUT_W: out_we = p_ok && t_ok;
            default: ;
          endcase
        end
      end

      pnfe_pkg::ST_SCAN: begin
        // issue the read for place cnt_q while stage b works on the one before
        if (cnt_q != CNT_W'(P_EFF)) begin
          b_vld_d = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
        end else begin
          state_d = pnfe_pkg::ST_FINISH;
        end
        if (b_vld_q) begin
          raw_d     = raw_q & ~clr;
          sat_d     = sat_q | b_sat;
          tok_we    = fire_q;
          tok_waddr = b_idx_q;
          tok_wdata = new_tok;
          if (p_ok_q && (b_idx_q == p_q[IDX_W-1:0])) begin
            tokv_d = new_low[pnfe_pkg::VALUE_W-1:0];
          end
        end
      end

      pnfe_pkg::ST_FINISH: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pnfe_pkg::ST_IDLE;
        end
      end

      default: state_d = pnfe_pkg::ST_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    out_item_d = out_item_q;
    out_vld_d  = out_vld_q && out_stall_i;
    if (out_load) begin
      out_vld_d                = 1'b1;
      out_item_d.enabled_mask  = eng_q ? raw_q : '0;
      out_item_d.token_value   = ((cmd_q == pnfe_pkg::CMD_RD_TOKEN) && p_ok_q) ? tokv_q : '0;
      if ((cmd_q == pnfe_pkg::CMD_FIRE) && !fire_q) begin
        out_item_d.status = pnfe_pkg::STATUS_REJECT;
      end else if (fire_q && sat_q) begin
        out_item_d.status = pnfe_pkg::STATUS_SAT;
      end else begin
        out_item_d.status = pnfe_pkg::STATUS_OK;
      end
    end
  end

  // config write, only the engine_on register exists
  always_comb begin
    eng_d = eng_q;
    if (psel && penable && pwrite && (paddr[2] == pnfe_pkg::REG_ENGINE_ON)) begin
      eng_d = pwdata[0];
    end
  end

  assign prdata = (paddr[2] == pnfe_pkg::REG_ENGINE_ON)
                ? {{(pnfe_pkg::PDATA_W-1){1'b0}}, eng_q} : '0;
  assign pready = 1'b1;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pnfe_pkg::ST_CLEAR;
      cnt_q     <= '0;
      raw_q     <= LANE_ALL;  // all weights zero after the clearing pass
      b_vld_q   <= 1'b0;
      eng_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      raw_q     <= raw_d;
      b_vld_q   <= b_vld_d;
      eng_q     <= eng_d;
      out_vld_q <= out_vld_d;
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= pnfe_pkg::cmd_e'(in_item_i.cmd);
      p_q    <= in_item_i.place_index;
      t_q    <= in_item_i.transition_index;
      p_ok_q <= p_ok;
      fire_q <= (pnfe_pkg::cmd_e'(in_item_i.cmd) == pnfe_pkg::CMD_FIRE) && fire_ok;
    end
    sat_q      <= sat_d;
    tokv_q     <= tokv_d;
    b_idx_q    <= b_idx_d;
    out_item_q <= out_item_d;
  end

  // marking memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tok_we) begin
      tok_mem_q[tok_waddr] <= tok_wdata;
    end
    tok_rdata_q <= tok_mem_q[rd_addr];
  end

  pnfe_wt_mem #(
    .ROWS  (P_EFF),
    .LANES (LANES)
  ) u_in_wt (
    .clk_i     (clk_i),
    .we_i      (in_we),
    .waddr_i   (wt_waddr),
    .lane_we_i (wt_lane_we),
    .wdata_i   (wt_wdata),
    .raddr_i   (rd_addr),
    .rdata_o   (in_row)
  );

  pnfe_wt_mem #(
    .ROWS  (P_EFF),
    .LANES (LANES)
  ) u_out_wt (
    .clk_i     (clk_i),
    .we_i      (out_we),
    .waddr_i   (wt_waddr),
    .lane_we_i (wt_lane_we),
    .wdata_i   (wt_wdata),
    .raddr_i   (rd_addr),
    .rdata_o   (out_row)
  );

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== test/pnfe_test_pkg.sv =====
`timescale 1ns / 1ps
// marking tracker for the petri net firing engine test, plus test constants
// depends on pnfe_pkg

package pnfe_test_pkg;
  import pnfe_pkg::*;

  localparam int unsigned NUM_PLACES = 16;
  localparam int unsigned NUM_TRANS  = 16;
  localparam int unsigned TOKEN_W    = 16;

  // command codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  localparam logic [PADDR_W-1:0] ADDR_ENGINE_ON = 3'd0;

  class marking_tracker;
    logic [TOKEN_W-1:0]  tokens [NUM_PLACES];
    logic [WEIGHT_W-1:0] in_weight [NUM_PLACES*NUM_TRANS];
    logic [WEIGHT_W-1:0] out_weight [NUM_PLACES*NUM_TRANS];
    bit                  engine_on;
    out_item_t           due_results [$];
    int unsigned         errors;

    function new();
      foreach (tokens[p]) tokens[p] = '0;
      foreach (in_weight[i]) in_weight[i] = '0;
      foreach (out_weight[i]) out_weight[i] = '0;
      engine_on = 1'b0;
      errors = 0;
    endfunction

    function bit can_fire(int unsigned t);
      if (!engine_on) return 1'b0;
      for (int unsigned p = 0; p < NUM_PLACES; p++) begin
        if (tokens[p] < in_weight[t*NUM_PLACES+p]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic [MASK_W-1:0] enabled_mask();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int unsigned t = 0; t < NUM_TRANS; t++) m[t] = can_fire(t);
      return m;
    endfunction

    // apply an accepted item to the marking and queue the result it causes
    function void take_item(in_item_t it);
      out_item_t         res;
      int unsigned       p;
      int unsigned       t;
      logic [TOKEN_W:0]  sum;
      res = '0;
      res.status = STATUS_OK;
      p = it.place_index;
      t = it.transition_index;
      case (it.cmd)
        CMD_WR_TOKEN: tokens[p] = it.value;
        CMD_WR_IN_W:  in_weight[t*NUM_PLACES+p] = it.value;
        CMD_WR_OUT_W: out_weight[t*NUM_PLACES+p] = it.value;
        CMD_FIRE: begin
          if (!can_fire(t)) begin
            res.status = STATUS_REJECT;
          end else begin
            for (int unsigned q = 0; q < NUM_PLACES; q++) begin
              sum = {1'b0, tokens[q]} - {1'b0, in_weight[t*NUM_PLACES+q]}
                  + {1'b0, out_weight[t*NUM_PLACES+q]};
              if (sum[TOKEN_W]) begin
                tokens[q] = '1;
                res.status = STATUS_SAT;
              end else begin
                tokens[q] = sum[TOKEN_W-1:0];
              end
            end
          end
        end
        CMD_RD_TOKEN: res.token_value = tokens[p];
        default: ;
      endcase
      res.enabled_mask = enabled_mask();
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with no item outstanding: status %0d mask %h token %0d",
               got.status, got.enabled_mask, got.token_value);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("enabled_mask", want.enabled_mask, got.enabled_mask);
      compare_field("token_value", want.token_value, got.token_value);
    endfunction
  endclass

endpackage

// ===== test/petri_net_firing_engine_test.sv =====
`timescale 1ns / 1ps
// self-checking test of the petri net firing engine: directed and random items
// depends on pnfe_pkg, pnfe_test_pkg and the petri_net_firing_engine rtl

module petri_net_firing_engine_test;
  import pnfe_pkg::*;
  import pnfe_test_pkg::*;

  localparam int unsigned GAP_MAX        = 17;
  localparam int unsigned LONG_HOLD      = 300;   // receiver hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES  = 24;    // longer than one unstalled item takes
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 356;
  localparam int unsigned NUM_PHASES     = 4;
  localparam int unsigned REGIME_LEN     = 40;    // items per idling regime

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PADDR_W-1:0]   paddr       = '0;
  logic [PDATA_W-1:0]   pwdata      = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  marking_tracker tracker;
  in_item_t       plan_q [$];
  int unsigned    idle_cycles   = 0;
  int unsigned    sent_count    = 0;
  int unsigned    results_seen  = 0;
  bit             tx_quiet      = 1'b0;
  bit             rx_quiet      = 1'b0;
  bit             tx_up         = 1'b0;   // in_valid_i is being held high
  bit             hold_off_req  = 1'b0;   // asks the receiver for one long hold-off

  // engine setting of each random phase, both extremes included
  bit phase_engine [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1};

  petri_net_firing_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------

  function automatic in_item_t mk_item(logic [CMD_W-1:0] cmd, int unsigned p,
                                       int unsigned t, int unsigned v);
    in_item_t it;
    it.cmd              = cmd;
    it.place_index      = INDEX_W'(p);
    it.transition_index = INDEX_W'(t);
    it.value            = VALUE_W'(v);
    return it;
  endfunction

  // weights: mostly no arc or a small one, now and then huge
  function automatic int unsigned pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 4);
    if (r == 8) return $urandom_range(0, 16'hFFFF);
    return 16'hFFFF - $urandom_range(0, 2);
  endfunction

  // token counts: small enough to fire a few times, sometimes close to the top
  function automatic int unsigned pick_tokens();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 40);
    if (r < 8) return $urandom_range(41, 3000);
    if (r == 8) return $urandom_range(0, 16'hFFFF);
    return 16'hFFFF - $urandom_range(0, 4);
  endfunction

  // a well-formed sequence: set up arcs and tokens around one transition, then fire it
  function automatic void plan_burst();
    int unsigned t;
    int unsigned p;
    t = $urandom_range(0, NUM_TRANS-1);
    repeat ($urandom_range(1, 3)) begin
      p = $urandom_range(0, NUM_PLACES-1);
      plan_q.push_back(mk_item(CMD_WR_IN_W, p, t, pick_weight()));
      plan_q.push_back(mk_item(CMD_WR_TOKEN, p, $urandom, pick_tokens()));
      plan_q.push_back(mk_item(CMD_WR_OUT_W, $urandom, t, pick_weight()));
    end
    repeat ($urandom_range(1, 4)) begin
      plan_q.push_back(mk_item(CMD_FIRE, $urandom, t, $urandom));
      if ($urandom_range(0, 1) == 1)
        plan_q.push_back(mk_item(CMD_RD_TOKEN, $urandom, $urandom, $urandom));
    end
  endfunction

  // anything at all, spare command codes included
  function automatic void plan_noise();
    plan_q.push_back(mk_item(CMD_W'($urandom_range(0, 2**CMD_W - 1)),
                             $urandom, $urandom, $urandom));
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  task automatic hold_input();
    if (tx_up) begin
      in_valid_i <= 1'b0;
      tx_up = 1'b0;
    end
  endtask

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (sent_count % REGIME_LEN == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      hold_input();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    tx_up = 1'b1;
    // values read right after the edge are the ones the block saw at it
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.take_item(it);
    sent_count++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    hold_input();
    while (tracker.due_results.size() != 0) @(posedge clk_i);
  endtask

  // apb write of engine_on, only with the engine idle
  task automatic set_engine(bit on);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENGINE_ON;
    pwdata  <= PDATA_W'(on);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.engine_on = on;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned k;
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // engine off: every fire is turned down, writes still land
    set_engine(1'b0);
    send_item(mk_item(CMD_FIRE, 0, 0, 0));
    send_item(mk_item(CMD_WR_TOKEN, 15, 0, 16'hFFFF));
    send_item(mk_item(CMD_RD_TOKEN, 15, 0, 0));
    send_item(mk_item(CMD_WR_IN_W, 0, 15, 16'hFFFF));
    send_item(mk_item(CMD_WR_OUT_W, 15, 0, 1));
    send_item(mk_item(CMD_SPARE_LO, 15, 15, 16'hFFFF));
    send_item(mk_item(CMD_SPARE_HI, 0, 0, 0));
    send_item(mk_item(CMD_RD_TOKEN, 0, 15, 16'hFFFF));

    // engine on
    set_engine(1'b1);
    send_item(mk_item(CMD_FIRE, 15, 0, 0));           // full place gets one more: saturates
    send_item(mk_item(CMD_FIRE, 0, 15, 0));           // needs the whole range in place 0
    send_item(mk_item(CMD_WR_TOKEN, 0, 0, 16'hFFFF));
    send_item(mk_item(CMD_FIRE, 0, 15, 16'hFFFF));    // drains place 0 to zero
    send_item(mk_item(CMD_RD_TOKEN, 0, 0, 0));
    send_item(mk_item(CMD_WR_IN_W, 0, 15, 0));
    send_item(mk_item(CMD_WR_IN_W, 3, 2, 1));
    send_item(mk_item(CMD_WR_TOKEN, 3, 0, 0));
    send_item(mk_item(CMD_FIRE, 0, 2, 0));            // one token short
    send_item(mk_item(CMD_WR_TOKEN, 3, 0, 1));
    send_item(mk_item(CMD_FIRE, 0, 2, 0));            // exactly enough
    send_item(mk_item(CMD_RD_TOKEN, 3, 0, 0));
    send_item(mk_item(CMD_WR_OUT_W, 15, 0, 0));
    send_item(mk_item(CMD_SPARE_MID, 7, 9, 16'h5A5A));
    send_item(mk_item(CMD_WR_IN_W, 3, 2, 0));

    // random phases, mostly well-formed bursts with noise in between
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      set_engine(phase_engine[ph]);
      plan_q.delete();
      while (plan_q.size() < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) plan_noise();
        else plan_burst();
      end
      k = 0;
      foreach (plan_q[i]) begin
        // first phase: fill the block behind a long receiver hold-off,
        // later let it run dry with the sender paused
        if (ph == 0 && k == 100) hold_off_req = 1'b1;
        if (ph == 0 && k == 250) wait_drained();
        send_item(plan_q[i]);
        k++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("petri_net_firing_engine: match");
    end else begin
      $display("petri_net_firing_engine: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stall after each result, one long hold-off on request
  // --------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        tracker.check_result(out_item_o);
        results_seen++;
        if (results_seen % REGIME_LEN == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        hold = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (hold_off_req) begin
          hold = LONG_HOLD;
          hold_off_req = 1'b0;
        end
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // watchdog: too long with nothing moving on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("petri_net_firing_engine: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
